>>> hdl/degree_trig_unit_assert.svh
// Assertion macros for the degree trig unit.
// Included by the top level; expects clk and arst_n in the including scope.
`ifndef DEGREE_TRIG_UNIT_ASSERT_SVH
`define DEGREE_TRIG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DTU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DTU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DTU_ASSERT_IMPLY(label, ante, cons, msg)
`define DTU_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> hdl/dtu_pkg.sv
// Shared types, constants and elaboration-time table functions for the degree trig unit.
// Depends on nothing; used by every module of the block.
package dtu_pkg;

	localparam int CORDIC_STEPS_DEF = 32;
	localparam int ANGLE_FRAC_DEF = 16;
	localparam int Z_FRAC = 55;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;

	localparam logic [47:0] MAX_MAG = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MAG = 48'h8000_0000_0001;
	localparam logic [47:0] ONE_Q30 = 48'd1073741824;
	localparam logic [47:0] HALF_Q30 = 48'd536870912;
	localparam logic [47:0] RT_HALF_Q30 = 48'd759250125;
	localparam logic [47:0] RT3_HALF_Q30 = 48'd929887697;
	localparam logic [47:0] INV_RT3_Q30 = 48'd619925131;
	localparam logic [47:0] RT3_Q30 = 48'd1859775393;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] angle;
	} in_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic infinite;
		logic negative_infinity;
		logic saturated;
	} out_t;

	typedef struct packed {
		logic [1:0] op;
		logic oppose;
		logic special;
		logic inf;
		logic ninf;
		logic [47:0] spec_mag;
	} side_t;

	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] t;
		logic [63:0] k;
		logic neg;
		p = udiv64(64'h4000_0000_0000_0000, n);
		sum = '0;
		k = '0;
		neg = 1'b0;
		while (p != 64'd0) begin
			t = udiv64(p, {k[62:0], 1'b1});
			sum = neg ? sum - t : sum + t;
			neg = !neg;
			k = k + 64'd1;
			p = udiv64(udiv64(p, n), n);
		end
		return sum;
	endfunction

	function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] q);
		logic [63:0] r;
		logic [63:0] rem;
		r = '0;
		rem = a;
		if (rem >= q) begin
			r = 64'd1;
			rem = rem - q;
		end
		for (int b = 0; b < Z_FRAC; b++) begin
			rem = rem << 1;
			r = r << 1;
			if (rem >= q) begin
				rem = rem - q;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] quarter;
		logic [63:0] a;
		logic [127:0] prod;
		quarter = atan_recip(64'd2) + atan_recip(64'd3);
		if (i == 0) begin
			a = quarter;
		end else if (i < 63) begin
			a = atan_recip(64'd1 << i);
		end else begin
			a = '0;
		end
		prod = {64'd0, frac_div(a, quarter)} * 128'd45;
		return prod[63:0];
	endfunction

	function automatic logic [63:0] cordic_gain(input int steps);
		logic [63:0] p2;
		logic [63:0] one;
		logic [63:0] k;
		logic [63:0] c;
		logic [127:0] m1;
		logic [127:0] m2;
		one = 64'd1 << 60;
		p2 = one;
		k = '0;
		for (int i = 0; i < steps && i < 32; i++) begin
			p2 = p2 + (p2 >> (2 * i));
		end
		for (int b = 60; b >= 0; b--) begin
			c = k | (64'd1 << b);
			m1 = {64'd0, c} * {64'd0, c};
			m2 = {64'd0, m1[123:60]} * {64'd0, p2};
			if (m2[123:60] <= one) begin
				k = c;
			end
		end
		return k;
	endfunction

endpackage

>>> hdl/dtu_reduce.sv
// Angle reduction, quadrant folding and exact-angle detection, six pipeline stages.
// Depends on dtu_pkg.
module dtu_reduce #(
	parameter int FRAC = dtu_pkg::ANGLE_FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  dtu_pkg::in_t        in_cmd,
	output logic                out_valid,
	output dtu_pkg::side_t      out_side,
	output logic signed [63:0]  out_z
);

	localparam int HW = 32 - (FRAC + 2);
	localparam int OFFQ = (2 ** (HW - 1) + 44) / 45;
	localparam int OFF = 45 * OFFQ;
	localparam int UW = HW + 1;
	localparam int QW = UW - 5;
	localparam int PW = UW + 27;
	localparam int RW = FRAC + 9;
	localparam int FW = FRAC + 7;
	localparam logic [26:0] RECIP = 27'd95443717;
	localparam logic [RW-1:0] C90 = RW'(longint'(90) << FRAC);
	localparam logic [RW-1:0] C180 = RW'(longint'(180) << FRAC);
	localparam logic [FW-1:0] F30 = FW'(longint'(30) << FRAC);
	localparam logic [FW-1:0] F45 = FW'(longint'(45) << FRAC);
	localparam logic [FW-1:0] F60 = FW'(longint'(60) << FRAC);
	localparam logic [FW-1:0] F90 = FW'(longint'(90) << FRAC);
	localparam logic OFF_PAR = OFFQ[0];

	logic signed [31:0] sh_tan;
	logic signed [31:0] sh_sc;
	logic [HW-1:0] h_sel;
	logic [UW-1:0] hu_d;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [UW-1:0] hu_s1, hu_s2;
	logic [FRAC+2:0] low_s1, low_s2;
	logic [1:0] op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [PW-1:0] prod_s2;
	logic [RW-1:0] r_s3, r_s4;
	logic par_s3, par_s4, par_s5;
	logic opp_s4, opp_s5;
	logic [FW-1:0] rr_s5;
	dtu_pkg::side_t side_s6;
	logic signed [63:0] z_s6;

	logic [QW-1:0] q_est;
	logic [UW-1:0] rem_full;
	logic [6:0] rem7;
	logic fix;
	logic [5:0] rem6;
	logic [RW-1:0] r_d3;
	logic [RW-1:0] r_d4;
	logic opp_d4;
	logic gt;
	logic [RW-1:0] rr_d5;
	logic opp_d5;
	dtu_pkg::side_t side_d6;

	assign sh_tan = in_cmd.angle >>> (FRAC + 2);
	assign sh_sc = in_cmd.angle >>> (FRAC + 3);
	assign h_sel = (in_cmd.operation == dtu_pkg::OP_TAN) ? sh_tan[HW-1:0] : sh_sc[HW-1:0];
	assign hu_d = UW'($signed(h_sel)) + UW'(OFF);

	assign q_est = prod_s2[PW-1:32];
	assign rem_full = hu_s2 - UW'(q_est) * UW'(45);
	assign rem7 = rem_full[6:0];
	assign fix = rem7 >= 7'd45;
	assign rem6 = fix ? 6'(rem7 - 7'd45) : rem7[5:0];
	assign r_d3 = (op_s2 == dtu_pkg::OP_TAN) ? RW'({rem6, low_s2[FRAC+1:0]})
		: {rem6, low_s2};

	always_comb begin
		r_d4 = r_s3;
		opp_d4 = 1'b0;
		if (op_s3 != dtu_pkg::OP_TAN && r_s3 >= C180) begin
			r_d4 = r_s3 - C180;
			opp_d4 = 1'b1;
		end
	end

	assign gt = r_s4 > C90;

	always_comb begin
		rr_d5 = r_s4;
		opp_d5 = opp_s4;
		case (op_s4)
			dtu_pkg::OP_COS: begin
				rr_d5 = gt ? r_s4 - C90 : C90 - r_s4;
				opp_d5 = opp_s4 ^ gt;
			end
			dtu_pkg::OP_TAN: begin
				rr_d5 = gt ? C180 - r_s4 : r_s4;
				opp_d5 = gt;
			end
			default: begin
				rr_d5 = gt ? C180 - r_s4 : r_s4;
			end
		endcase
	end

	always_comb begin
		side_d6.op = op_s5;
		side_d6.oppose = opp_s5;
		side_d6.special = 1'b0;
		side_d6.inf = 1'b0;
		side_d6.ninf = 1'b0;
		side_d6.spec_mag = '0;
		case (op_s5) inside
			dtu_pkg::OP_SIN, dtu_pkg::OP_COS: begin
				if (rr_s5 == '0) begin
					side_d6.special = 1'b1;
				end else if (rr_s5 == F30) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::HALF_Q30;
				end else if (rr_s5 == F45) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::RT_HALF_Q30;
				end else if (rr_s5 == F60) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::RT3_HALF_Q30;
				end else if (rr_s5 == F90) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::ONE_Q30;
				end
			end
			dtu_pkg::OP_TAN: begin
				if (rr_s5 == '0) begin
					side_d6.special = 1'b1;
				end else if (rr_s5 == F30) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::INV_RT3_Q30;
				end else if (rr_s5 == F45) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::ONE_Q30;
				end else if (rr_s5 == F60) begin
					side_d6.special = 1'b1;
					side_d6.spec_mag = dtu_pkg::RT3_Q30;
				end else if (rr_s5 == F90) begin
					side_d6.special = 1'b1;
					side_d6.inf = 1'b1;
					side_d6.ninf = par_s5;
					side_d6.oppose = par_s5;
					side_d6.spec_mag = dtu_pkg::MAX_MAG;
				end
			end
			default: begin
				side_d6.special = 1'b1;
				side_d6.oppose = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		hu_s1 <= hu_d;
		low_s1 <= in_cmd.angle[FRAC+2:0];
		op_s1 <= in_cmd.operation;
		prod_s2 <= PW'(hu_s1) * PW'(RECIP);
		hu_s2 <= hu_s1;
		low_s2 <= low_s1;
		op_s2 <= op_s1;
		r_s3 <= r_d3;
		par_s3 <= q_est[0] ^ fix ^ OFF_PAR;
		op_s3 <= op_s2;
		r_s4 <= r_d4;
		opp_s4 <= opp_d4;
		par_s4 <= par_s3;
		op_s4 <= op_s3;
		rr_s5 <= rr_d5[FW-1:0];
		opp_s5 <= opp_d5;
		par_s5 <= par_s4;
		op_s5 <= op_s4;
		side_s6 <= side_d6;
		z_s6 <= $signed(64'(rr_s5) << (dtu_pkg::Z_FRAC - FRAC));
	end

	assign out_valid = v_s6;
	assign out_side = side_s6;
	assign out_z = z_s6;

endmodule

>>> hdl/dtu_cordic.sv
// Unrolled rotation-mode CORDIC in degrees, one register stage per iteration.
// Depends on dtu_pkg for the arctangent table and the gain constant.
module dtu_cordic #(
	parameter int STEPS = dtu_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  dtu_pkg::side_t      in_side,
	input  logic signed [63:0]  in_z,
	output logic                out_valid,
	output dtu_pkg::side_t      out_side,
	output logic signed [63:0]  out_x,
	output logic signed [63:0]  out_y
);

	localparam logic signed [63:0] GAIN = $signed(dtu_pkg::cordic_gain(STEPS));

	logic v_s [STEPS];
	dtu_pkg::side_t side_s [STEPS];
	logic signed [63:0] x_s [STEPS];
	logic signed [63:0] y_s [STEPS];
	logic signed [63:0] z_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int SH = (i > 63) ? 63 : i;
		localparam logic signed [63:0] ATAN = $signed(dtu_pkg::atan_entry(i));
		logic vi;
		dtu_pkg::side_t si;
		logic signed [63:0] xi, yi, zi, dx, dy;

		if (i == 0) begin : g_first
			assign vi = in_valid;
			assign si = in_side;
			assign xi = GAIN;
			assign yi = '0;
			assign zi = in_z;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign si = side_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end

		assign dx = yi >>> SH;
		assign dy = xi >>> SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			side_s[i] <= si;
			if (!zi[63]) begin
				x_s[i] <= xi - dx;
				y_s[i] <= yi + dy;
				z_s[i] <= zi - ATAN;
			end else begin
				x_s[i] <= xi + dx;
				y_s[i] <= yi - dy;
				z_s[i] <= zi + ATAN;
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign out_side = side_s[STEPS-1];
	assign out_x = x_s[STEPS-1];
	assign out_y = y_s[STEPS-1];

endmodule

>>> hdl/dtu_divide.sv
// Output scaling, pipelined restoring divider for tangent, sign and flag assembly.
// Depends on dtu_pkg; fifty register stages.
module dtu_divide (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  dtu_pkg::side_t      in_side,
	input  logic signed [63:0]  in_x,
	input  logic signed [63:0]  in_y,
	output logic                out_valid,
	output dtu_pkg::out_t       out_result
);

	localparam int QB = 48;
	localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

	typedef struct packed {
		logic oppose;
		logic inf;
		logic ninf;
		logic sat;
		logic use_div;
		logic [47:0] mag;
	} meta_t;

	logic [60:0] yy, xx, yr;
	logic is_div, over;
	meta_t meta_d0;

	logic v_d0;
	meta_t meta_s0;
	logic [60:0] d_s0;
	logic [61:0] rem_s0;
	logic [16:0] ylo_s0;

	logic v_s [QB];
	meta_t meta_s [QB];
	logic [60:0] d_s [QB];
	logic [61:0] rem_s [QB];
	logic [16:0] ylo_s [QB];
	logic [QB-1:0] q_s [QB];

	logic [QB-1:0] qf;
	logic [QB:0] qinc;
	logic full;
	logic [47:0] mag_f;
	logic sat_f;
	dtu_pkg::out_t res_d;
	dtu_pkg::out_t result_q;
	logic done_q;

	assign yy = in_y[63] ? '0 : (in_y > $signed(64'(ONE_Q60))) ? ONE_Q60 : in_y[60:0];
	assign xx = in_x[63] ? '0 : (in_x > $signed(64'(ONE_Q60))) ? ONE_Q60 : in_x[60:0];
	assign yr = yy + (61'd1 << 29);
	assign is_div = in_side.op == dtu_pkg::OP_TAN && !in_side.special;
	assign over = (in_x <= 64'sd0) || ({17'd0, yy} >= {xx, 17'd0});

	always_comb begin
		meta_d0.oppose = in_side.oppose;
		meta_d0.inf = in_side.inf;
		meta_d0.ninf = in_side.ninf;
		meta_d0.sat = is_div && over;
		meta_d0.use_div = is_div && !over;
		if (in_side.special) begin
			meta_d0.mag = in_side.spec_mag;
		end else if (in_side.op == dtu_pkg::OP_SIN || in_side.op == dtu_pkg::OP_COS) begin
			meta_d0.mag = 48'(yr[60:30]);
		end else if (is_div && over) begin
			meta_d0.mag = dtu_pkg::MAX_MAG;
		end else begin
			meta_d0.mag = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d0 <= 1'b0;
		end else begin
			v_d0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s0 <= meta_d0;
		d_s0 <= xx;
		rem_s0 <= 62'(yy[60:17]);
		ylo_s0 <= yy[16:0];
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		logic vi;
		meta_t mi;
		logic [60:0] di;
		logic [61:0] ri;
		logic [16:0] li;
		logic [QB-1:0] qi;
		logic nb;
		logic [61:0] trial;
		logic ge;

		if (j == 0) begin : g_first
			assign vi = v_d0;
			assign mi = meta_s0;
			assign di = d_s0;
			assign ri = rem_s0;
			assign li = ylo_s0;
			assign qi = '0;
		end else begin : g_next
			assign vi = v_s[j-1];
			assign mi = meta_s[j-1];
			assign di = d_s[j-1];
			assign ri = rem_s[j-1];
			assign li = ylo_s[j-1];
			assign qi = q_s[j-1];
		end

		if (j < 17) begin : g_feed
			assign nb = li[16-j];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign trial = {ri[60:0], nb};
		assign ge = trial >= {1'b0, di};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			meta_s[j] <= mi;
			d_s[j] <= di;
			ylo_s[j] <= li;
			rem_s[j] <= ge ? trial - {1'b0, di} : trial;
			q_s[j] <= {qi[QB-2:0], ge};
		end
	end

	assign qf = q_s[QB-1];
	assign qinc = {1'b0, qf} + {{QB{1'b0}}, 1'b1};
	assign full = &qf;

	always_comb begin
		mag_f = meta_s[QB-1].mag;
		sat_f = meta_s[QB-1].sat;
		if (meta_s[QB-1].use_div) begin
			mag_f = full ? dtu_pkg::MAX_MAG : qinc[QB:1];
			sat_f = full;
		end
		res_d.value = meta_s[QB-1].oppose ? $signed(-mag_f) : $signed(mag_f);
		res_d.infinite = meta_s[QB-1].inf;
		res_d.negative_infinity = meta_s[QB-1].ninf;
		res_d.saturated = sat_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign out_valid = done_q;
	assign out_result = result_q;

endmodule

>>> hdl/degree_trig_unit.sv
// Top level of the degree trig unit: sine, cosine or tangent of a Q16.16 angle in degrees.
// Depends on dtu_pkg, dtu_reduce, dtu_cordic, dtu_divide and the assertion header.
//
// A transaction is a command (operation and angle) presented with start; it is taken
// at every rising edge where start is high, and busy is never raised, so a new
// command may enter on every cycle. Each command yields exactly one result, shown
// on result for one cycle with done high, in the order the commands came in.
// Between command and result lie the angle reduction and folding stages, a register per
// CORDIC iteration, a scaling register, a register per quotient bit of the 48-bit
// tangent divider and an output register. Throughput is one result per cycle; every
// stage is a register, none is shared. The receiver has no way to stall, so done and
// result are valid only in that one cycle. Reset clears all valid bits at once;
// commands in flight are dropped and nothing comes out until a new command has gone
// through the whole pipeline.
`include "degree_trig_unit_assert.svh"
module degree_trig_unit #(
	parameter int CORDIC_STEPS = dtu_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRACTION_BITS = dtu_pkg::ANGLE_FRAC_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dtu_pkg::in_t   command,
	output logic           done,
	output dtu_pkg::out_t  result
);

	localparam int LAT = 56 + CORDIC_STEPS;

	logic red_valid;
	dtu_pkg::side_t red_side;
	logic signed [63:0] red_z;
	logic cor_valid;
	dtu_pkg::side_t cor_side;
	logic signed [63:0] cor_x, cor_y;

	assign busy = 1'b0;

	dtu_reduce #(
		.FRAC(ANGLE_FRACTION_BITS)
	) u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.in_cmd(command),
		.out_valid(red_valid),
		.out_side(red_side),
		.out_z(red_z)
	);

	dtu_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(red_valid),
		.in_side(red_side),
		.in_z(red_z),
		.out_valid(cor_valid),
		.out_side(cor_side),
		.out_x(cor_x),
		.out_y(cor_y)
	);

	dtu_divide u_divide (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cor_valid),
		.in_side(cor_side),
		.in_x(cor_x),
		.in_y(cor_y),
		.out_valid(done),
		.out_result(result)
	);

	`DTU_ASSERT_IMPLY(a_latency, done, $past(start && !busy, LAT), "result without a command")
	`DTU_ASSERT_IMPLY(a_inf_value, done && result.infinite, (result.value == dtu_pkg::MAX_MAG) || (result.value == dtu_pkg::NEG_MAG), "infinity with wrong value")
	`DTU_ASSERT_NEVER(a_inf_sat, done && result.infinite && result.saturated, "infinity and saturation together")
	`DTU_ASSERT_NEVER(a_ninf, done && result.negative_infinity && !result.infinite, "infinity sign without infinity")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for degree_trig_unit: sine, cosine and tangent in degrees.
// Depends on dtu_pkg and degree_trig_unit; a built-in CORDIC predictor checks each result.
`timescale 1ns / 100ps
module tb_top;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	dtu_pkg::in_t command = '0;
	logic done;
	dtu_pkg::out_t result;

	dtu_pkg::in_t pending_cmds[$];
	dtu_pkg::out_t trig_expected[$];
	longint atan_deg[64];
	bit [63:0] cordic_k;
	int unsigned issued = 0;
	int unsigned gap = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	degree_trig_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.done(done),
		.result(result)
	);

	function automatic bit [63:0] arctan_inv(bit [63:0] n);
		bit [63:0] p;
		bit [63:0] sum;
		bit [63:0] k;
		bit neg;
		p = (64'd1 << 62) / n;
		sum = 0;
		k = 0;
		neg = 0;
		while (p != 0) begin
			if (neg) sum = sum - p / (2 * k + 1);
			else sum = sum + p / (2 * k + 1);
			neg = !neg;
			k++;
			p = p / n / n;
		end
		return sum;
	endfunction

	function automatic bit [63:0] ratio_q55(bit [63:0] a, bit [63:0] q);
		bit [63:0] r;
		bit [63:0] rem;
		r = 0;
		rem = a;
		if (rem >= q) begin
			r = 1;
			rem -= q;
		end
		for (int b = 0; b < 55; b++) begin
			rem = rem << 1;
			r = r << 1;
			if (rem >= q) begin
				rem -= q;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic bit [63:0] fix60_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic bit [63:0] unit_clamp(longint v);
		if (v < 0) return 0;
		if (v > (longint'(1) <<< 60)) return 64'd1 << 60;
		return v;
	endfunction

	function automatic void rotate(longint theta, output longint cx, output longint sy);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = cordic_k;
		y = 0;
		z = theta;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_deg[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_deg[i];
			end
		end
		cx = x;
		sy = y;
	endfunction

	function automatic dtu_pkg::out_t predict_trig(dtu_pkg::in_t c);
		longint c90;
		longint c180;
		longint c360;
		longint a;
		longint r;
		longint cyc;
		longint cx;
		longint sy;
		bit [63:0] mag;
		bit [63:0] yy;
		bit [63:0] xx;
		bit [63:0] q;
		bit [63:0] rem;
		bit [47:0] v;
		bit oppose;
		dtu_pkg::out_t o;
		c90 = longint'(90) <<< 16;
		c180 = 2 * c90;
		c360 = 4 * c90;
		a = c.angle;
		mag = 0;
		oppose = 0;
		o = '0;
		if (c.operation == dtu_pkg::OP_SIN || c.operation == dtu_pkg::OP_COS) begin
			r = a % c360;
			if (r < 0) r += c360;
			if (r >= c180) begin
				oppose = 1;
				r -= c180;
			end
			if (r > c90) begin
				r = c180 - r;
				if (c.operation == dtu_pkg::OP_COS) oppose = !oppose;
			end
			if (c.operation == dtu_pkg::OP_COS) r = c90 - r;
			if (r == 0) mag = 0;
			else if (r == c90 / 3) mag = dtu_pkg::HALF_Q30;
			else if (r == c90 / 2) mag = dtu_pkg::RT_HALF_Q30;
			else if (r == 2 * c90 / 3) mag = dtu_pkg::RT3_HALF_Q30;
			else if (r == c90) mag = dtu_pkg::ONE_Q30;
			else begin
				rotate(r <<< 39, cx, sy);
				mag = (unit_clamp(sy) + (64'd1 << 29)) >> 30;
			end
		end else if (c.operation == dtu_pkg::OP_TAN) begin
			cyc = a / c180;
			r = a % c180;
			if (r < 0) begin
				r += c180;
				cyc -= 1;
			end
			if (r > c90) begin
				oppose = 1;
				r = c180 - r;
			end
			if (r == 0) mag = 0;
			else if (r == c90 / 3) mag = dtu_pkg::INV_RT3_Q30;
			else if (r == c90 / 2) mag = dtu_pkg::ONE_Q30;
			else if (r == 2 * c90 / 3) mag = dtu_pkg::RT3_Q30;
			else if (r == c90) begin
				o.infinite = 1'b1;
				o.negative_infinity = cyc[0];
				oppose = cyc[0];
				mag = dtu_pkg::MAX_MAG;
			end else begin
				rotate(r <<< 39, cx, sy);
				yy = unit_clamp(sy);
				if (cx <= 0) begin
					o.saturated = 1'b1;
					mag = dtu_pkg::MAX_MAG;
				end else begin
					xx = unit_clamp(cx);
					q = yy / xx;
					rem = yy % xx;
					if ((q >> 17) != 0) begin
						o.saturated = 1'b1;
						mag = dtu_pkg::MAX_MAG;
					end else begin
						for (int i = 0; i < 31; i++) begin
							rem = rem << 1;
							q = q << 1;
							if (rem >= xx) begin
								rem -= xx;
								q[0] = 1'b1;
							end
						end
						q = (q + 1) >> 1;
						if (q > dtu_pkg::MAX_MAG) begin
							o.saturated = 1'b1;
							mag = dtu_pkg::MAX_MAG;
						end else begin
							mag = q;
						end
					end
				end
			end
		end
		v = mag[47:0];
		if (oppose) v = -v;
		o.value = v;
		return o;
	endfunction

	function automatic dtu_pkg::in_t random_cmd();
		dtu_pkg::in_t c;
		int unsigned sel;
		c.operation = $urandom_range(0, 9) == 0 ? OP_UNKNOWN : 2'($urandom_range(0, 2));
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			c.angle = 32'((int'($urandom_range(0, 4368)) - 2184) * 983040);
		end else if (sel < 6) begin
			c.angle = (($urandom_range(0, 48) - 24) * 15 <<< 16) + $urandom_range(0, 7) - 3;
		end else begin
			c.angle = $urandom;
		end
		return c;
	endfunction

	initial begin
		forever #10 clk = !clk;
	end

	initial begin
		longint directed_angles[6];
		dtu_pkg::in_t c;
		bit [63:0] quarter;
		bit [63:0] p2;
		bit [63:0] t;
		quarter = arctan_inv(2) + arctan_inv(3);
		for (int i = 0; i < 64; i++) begin
			t = i == 0 ? quarter : (i < 63 ? arctan_inv(64'd1 << i) : 64'd0);
			atan_deg[i] = ratio_q55(t, quarter) * 45;
		end
		p2 = 64'd1 << 60;
		for (int i = 0; i < 32; i++) p2 += p2 >> (2 * i);
		cordic_k = 0;
		for (int b = 60; b >= 0; b--) begin
			t = cordic_k | (64'd1 << b);
			if (fix60_mul(fix60_mul(t, t), p2) <= (64'd1 << 60)) cordic_k = t;
		end
		directed_angles = '{0, 30 <<< 16, 45 <<< 16, -(90 <<< 16), 32'h7FFF_FFFF,
			-64'sd2147483648};
		for (int op = 0; op < 4; op++) begin
			foreach (directed_angles[j]) begin
				c.operation = 2'(op);
				c.angle = 32'(directed_angles[j]);
				pending_cmds.push_back(c);
			end
		end
		c.operation = dtu_pkg::OP_TAN;
		c.angle = 270 <<< 16;
		pending_cmds.push_back(c);
		c.angle = 60 <<< 16;
		pending_cmds.push_back(c);
		repeat (1600) pending_cmds.push_back(random_cmd());
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || start) @(posedge clk);
		while (trig_expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
		end else begin
			if (start && !busy) begin
				trig_expected.push_back(predict_trig(command));
				issued++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap != 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0 &&
				!(issued < 1400 && $urandom_range(0, 15) == 0)) begin
				command <= pending_cmds.pop_front();
				start <= 1'b1;
			end else begin
				if (pending_cmds.size() != 0) gap <= $urandom_range(0, 16);
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		dtu_pkg::out_t want;
		if (arst_n && done) begin
			if (trig_expected.size() == 0) begin
				$display("%0t: unexpected transaction, actual %p", $time, result);
				errors++;
			end else begin
				want = trig_expected.pop_front();
				if (result.value !== want.value) begin
					$display("%0t: value expected %h actual %h", $time, want.value, result.value);
					errors++;
				end
				if (result.infinite !== want.infinite) begin
					$display("%0t: infinite expected %b actual %b", $time, want.infinite,
						result.infinite);
					errors++;
				end
				if (result.negative_infinity !== want.negative_infinity) begin
					$display("%0t: negative_infinity expected %b actual %b", $time,
						want.negative_infinity, result.negative_infinity);
					errors++;
				end
				if (result.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time, want.saturated,
						result.saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/dtu_pkg.sv
hdl/dtu_reduce.sv
hdl/dtu_cordic.sv
hdl/dtu_divide.sv
hdl/degree_trig_unit.sv
sim/tb_top.sv
